// ----- rtl/assert_macros.svh -----
// Assertion helpers for the RTL files; hbv_core includes them.
// Each check is sampled on clk and is off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must hold at every clock edge
`define HBV_ASSERT_HOLDS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// when ante holds, cons must hold at the next clock edge
`define HBV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/hbv_pkg.sv -----
package hbv_pkg;

    localparam int BYTE_W       = 8;
    localparam int PART_W       = 2;
    localparam int BODY_W       = 32;
    localparam int STATUS_W     = 3;
    localparam int SUM_W        = 25;
    localparam int HDR_LIMIT_W  = 24;
    localparam int PLEN_W       = 5;
    localparam int APB_DATA_W   = 32;
    localparam int PADDR_W      = 4;
    localparam int REG_IDX_W    = 2;

    localparam int NAME_TABLE_SIZE          = 6;
    localparam int MAX_NAME_LEN             = 17;
    localparam int RESERVED_NAME_COUNT_DEF  = 6;

    localparam logic [SUM_W-1:0]  SUM_MAX   = '1;
    localparam logic [PLEN_W-1:0] PLEN_MAX  = '1;
    localparam logic [SUM_W:0]    HDR_EXTRA = (SUM_W+1)'(4);

    // part codes
    localparam logic [PART_W-1:0] PART_METHOD = 2'd0;
    localparam logic [PART_W-1:0] PART_NAME   = 2'd1;
    localparam logic [PART_W-1:0] PART_VALUE  = 2'd2;
    localparam logic [PART_W-1:0] PART_SKIP   = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_METHOD = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_NAME   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_VALUE  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RESERVED   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_HDR_LARGE  = 3'd5;
    localparam logic [STATUS_W-1:0] ST_BODY_LARGE = 3'd6;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_MODE     = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_MAX_HDR  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_MAX_BODY = 2'd2;

    localparam logic                   MODE_RESET     = 1'b1;
    localparam logic [HDR_LIMIT_W-1:0] MAX_HDR_RESET  = 24'd8192;
    localparam logic [BODY_W-1:0]      MAX_BODY_RESET = 32'd1048576;

    // reserved framing names, lower case, right-justified in each entry
    localparam logic [MAX_NAME_LEN*BYTE_W-1:0] RSV_TEXT [NAME_TABLE_SIZE] = '{
        (MAX_NAME_LEN*BYTE_W)'("host"),
        (MAX_NAME_LEN*BYTE_W)'("content-length"),
        (MAX_NAME_LEN*BYTE_W)'("transfer-encoding"),
        (MAX_NAME_LEN*BYTE_W)'("connection"),
        (MAX_NAME_LEN*BYTE_W)'("expect"),
        (MAX_NAME_LEN*BYTE_W)'("upgrade")
    };
    localparam logic [PLEN_W-1:0] RSV_LEN [NAME_TABLE_SIZE] = '{
        5'd4, 5'd14, 5'd17, 5'd10, 5'd6, 5'd7
    };

    typedef struct packed {
        logic                   request_mode;
        logic [HDR_LIMIT_W-1:0] hdr_limit;
        logic [BODY_W-1:0]      body_limit;
    } cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic [PART_W-1:0] part;
        logic              has_byte;
        logic              end_of_part;
        logic              end_of_message;
        logic [BODY_W-1:0] body_length;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } stage_t;

    function automatic logic is_token_byte(input logic [BYTE_W-1:0] c);
        logic ok;
        ok = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A)
          || (c >= 8'h61 && c <= 8'h7A);
        case (c)
            8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B,
            8'h2D, 8'h2E, 8'h5E, 8'h5F, 8'h60, 8'h7C, 8'h7E: ok = 1'b1;
            default: ;
        endcase
        return ok;
    endfunction

    function automatic logic is_value_byte(input logic [BYTE_W-1:0] c);
        return (c == 8'h09) || (c >= 8'h20 && c != 8'h7F);
    endfunction

    function automatic logic [BYTE_W-1:0] to_lower(input logic [BYTE_W-1:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
    endfunction

    // character at position pos of reserved name idx; pos below its length
    function automatic logic [BYTE_W-1:0] rsv_char(input logic [2:0] idx,
                                                   input logic [PLEN_W-1:0] pos);
        logic [PLEN_W-1:0] back;
        back = RSV_LEN[idx] - pos - 5'd1;
        return BYTE_W'(RSV_TEXT[idx] >> {back, 3'b000});
    endfunction

    function automatic logic [STATUS_W-1:0] latch_err(input logic [STATUS_W-1:0] cur,
                                                      input logic [STATUS_W-1:0] code);
        return (cur == ST_OK) ? code : cur;
    endfunction

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] s,
                                                 input logic [SUM_W:0]   n);
        logic [SUM_W:0] t;
        t = {1'b0, s} + n;
        return (t > {1'b0, SUM_MAX}) ? SUM_MAX : t[SUM_W-1:0];
    endfunction

endpackage

// ----- rtl/hbv_ifs.sv -----
interface hbv_item_if;
    logic                          valid;
    logic                          ready;
    logic [hbv_pkg::BYTE_W-1:0]    data_byte;
    logic [hbv_pkg::PART_W-1:0]    part;
    logic                          has_byte;
    logic                          end_of_part;
    logic                          end_of_message;
    logic [hbv_pkg::BODY_W-1:0]    body_length;

    modport source (output valid, data_byte, part, has_byte, end_of_part,
                    end_of_message, body_length, input ready);
    modport sink   (input valid, data_byte, part, has_byte, end_of_part,
                    end_of_message, body_length, output ready);
endinterface

interface hbv_result_if;
    logic                          valid;
    logic                          ready;
    logic [hbv_pkg::STATUS_W-1:0]  status;
    logic [hbv_pkg::SUM_W-1:0]     hdr_total;

    modport source (output valid, status, hdr_total, input ready);
    modport sink   (input valid, status, hdr_total, output ready);
endinterface

// ----- rtl/hbv_cfg.sv -----
module hbv_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [hbv_pkg::PADDR_W-1:0]    paddr,
    input  logic [hbv_pkg::APB_DATA_W-1:0] pwdata,
    output logic [hbv_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output hbv_pkg::cfg_t                  cfg
);
    import hbv_pkg::*;

    logic                   mode_reg, mode_next;
    logic [HDR_LIMIT_W-1:0] max_hdr_reg, max_hdr_next;
    logic [BODY_W-1:0]      max_body_reg, max_body_next;
    logic [REG_IDX_W-1:0]   idx;
    logic                   wr;

    assign pready = 1'b1;
    assign idx    = paddr[PADDR_W-1:2];
    assign wr     = psel && penable && pwrite && pready;

    always_comb
    begin
        mode_next     = mode_reg;
        max_hdr_next  = max_hdr_reg;
        max_body_next = max_body_reg;
        if (wr)
        begin
            case (idx)
                REG_MODE:     mode_next     = pwdata[0];
                REG_MAX_HDR:  max_hdr_next  = pwdata[HDR_LIMIT_W-1:0];
                REG_MAX_BODY: max_body_next = pwdata[BODY_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_MODE:     prdata = APB_DATA_W'(mode_reg);
            REG_MAX_HDR:  prdata = APB_DATA_W'(max_hdr_reg);
            REG_MAX_BODY: prdata = APB_DATA_W'(max_body_reg);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_RESET;
            max_hdr_reg  <= MAX_HDR_RESET;
            max_body_reg <= MAX_BODY_RESET;
        end
        else
        begin
            mode_reg     <= mode_next;
            max_hdr_reg  <= max_hdr_next;
            max_body_reg <= max_body_next;
        end
    end

    assign cfg = '{request_mode: mode_reg, hdr_limit: max_hdr_reg,
                   body_limit: max_body_reg};

endmodule

// ----- rtl/hbv_in_stage.sv -----
module hbv_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    hbv_item_if.sink        items,
    input  logic            advance,
    output hbv_pkg::stage_t stage
);
    import hbv_pkg::*;

    logic  valid_reg, valid_next;
    item_t item_reg, item_next;
    logic  load;

    assign items.ready = !valid_reg || advance;
    assign load        = items.valid && items.ready;

    always_comb
    begin
        valid_next = load ? 1'b1 : (advance ? 1'b0 : valid_reg);
        item_next  = item_reg;
        if (load)
        begin
            item_next = '{data_byte: items.data_byte, part: items.part,
                          has_byte: items.has_byte, end_of_part: items.end_of_part,
                          end_of_message: items.end_of_message,
                          body_length: items.body_length};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign stage = '{valid: valid_reg, item: item_reg};

endmodule

// ----- rtl/hbv_core.sv -----
module hbv_core #(
    parameter int RESERVED_NAME_COUNT = hbv_pkg::RESERVED_NAME_COUNT_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  hbv_pkg::cfg_t   cfg,
    input  hbv_pkg::stage_t stage,
    output logic            advance,
    hbv_result_if.source    results
);
    import hbv_pkg::*;
    `include "assert_macros.svh"

    localparam int CAND_W = (RESERVED_NAME_COUNT > NAME_TABLE_SIZE)
                          ? NAME_TABLE_SIZE : RESERVED_NAME_COUNT;
    localparam logic [CAND_W-1:0] CAND_ALL = '1;

    logic [STATUS_W-1:0] err_reg, err_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [PLEN_W-1:0]   plen_reg, plen_next;
    logic [CAND_W-1:0]   cand_reg, cand_next;
    logic                chars_ok_reg, chars_ok_next;
    logic                method_ok_reg, method_ok_next;
    logic                name_rsv_reg, name_rsv_next;

    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [SUM_W-1:0]    hdr_reg, hdr_next;

    item_t               it;
    logic                out_free;
    logic                out_load;
    logic                skip;
    logic                byte_ok;
    logic [BYTE_W-1:0]   low;
    logic                rsv_hit;
    logic [STATUS_W-1:0] final_err;

    assign it       = stage.item;
    assign out_free = !out_valid_reg || results.ready;
    assign advance  = stage.valid && (!it.end_of_message || out_free);
    assign out_load = advance && it.end_of_message;
    assign skip     = (it.part == PART_SKIP) || (it.part == PART_METHOD && !cfg.request_mode);
    assign low      = to_lower(it.data_byte);

    always_comb
    begin
        err_next       = err_reg;
        sum_next       = sum_reg;
        plen_next      = plen_reg;
        cand_next      = cand_reg;
        chars_ok_next  = chars_ok_reg;
        method_ok_next = method_ok_reg;
        name_rsv_next  = name_rsv_reg;
        byte_ok        = 1'b1;
        rsv_hit        = 1'b0;
        final_err      = err_reg;

        if (advance && it.end_of_message)
        begin
            if (cfg.request_mode && !method_ok_reg)
                final_err = latch_err(final_err, ST_BAD_METHOD);
            if (it.body_length > cfg.body_limit)
                final_err = latch_err(final_err, ST_BODY_LARGE);
            err_next       = ST_OK;
            sum_next       = '0;
            method_ok_next = 1'b0;
            name_rsv_next  = 1'b0;
            plen_next      = '0;
            cand_next      = CAND_ALL;
            chars_ok_next  = 1'b1;
        end
        else if (advance && !skip)
        begin
            // apply the byte first
            if (it.has_byte)
            begin
                byte_ok = (it.part == PART_VALUE) ? is_value_byte(it.data_byte)
                                                  : is_token_byte(it.data_byte);
                if (!byte_ok)
                    chars_ok_next = 1'b0;
                if (it.part == PART_NAME)
                begin
                    for (int i = 0; i < CAND_W; i++)
                    begin
                        if (plen_reg >= RSV_LEN[i] || rsv_char(3'(i), plen_reg) != low)
                            cand_next[i] = 1'b0;
                    end
                end
                if (it.part != PART_METHOD)
                    sum_next = sat_add(sum_next, (SUM_W+1)'(1));
                if (plen_reg != PLEN_MAX)
                    plen_next = plen_reg + 5'd1;
            end

            // then close the part
            if (it.end_of_part)
            begin
                if (it.part == PART_METHOD)
                begin
                    if (chars_ok_next && plen_next != '0)
                        method_ok_next = 1'b1;
                    else
                        err_next = latch_err(err_next, ST_BAD_METHOD);
                end
                else
                begin
                    if (cfg.request_mode && !method_ok_reg)
                        err_next = latch_err(err_next, ST_BAD_METHOD);
                    if (it.part == PART_NAME)
                    begin
                        if (!chars_ok_next || plen_next == '0)
                            err_next = latch_err(err_next, ST_BAD_NAME);
                        for (int i = 0; i < CAND_W; i++)
                        begin
                            if (cand_next[i] && RSV_LEN[i] == plen_next)
                                rsv_hit = 1'b1;
                        end
                        name_rsv_next = rsv_hit;
                    end
                    else
                    begin
                        if (!chars_ok_next)
                            err_next = latch_err(err_next, ST_BAD_VALUE);
                        if (name_rsv_reg)
                            err_next = latch_err(err_next, ST_RESERVED);
                        name_rsv_next = 1'b0;
                        sum_next = sat_add(sum_next, HDR_EXTRA);
                        if (sum_next > {1'b0, cfg.hdr_limit})
                            err_next = latch_err(err_next, ST_HDR_LARGE);
                    end
                end
                plen_next     = '0;
                cand_next     = CAND_ALL;
                chars_ok_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_load ? 1'b1 : (results.ready ? 1'b0 : out_valid_reg);
        status_next    = out_load ? final_err : status_reg;
        hdr_next       = out_load ? sum_reg : hdr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_reg       <= ST_OK;
            sum_reg       <= '0;
            plen_reg      <= '0;
            cand_reg      <= CAND_ALL;
            chars_ok_reg  <= 1'b1;
            method_ok_reg <= 1'b0;
            name_rsv_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            err_reg       <= err_next;
            sum_reg       <= sum_next;
            plen_reg      <= plen_next;
            cand_reg      <= cand_next;
            chars_ok_reg  <= chars_ok_next;
            method_ok_reg <= method_ok_next;
            name_rsv_reg  <= name_rsv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        hdr_reg    <= hdr_next;
    end

    assign results.valid     = out_valid_reg;
    assign results.status    = status_reg;
    assign results.hdr_total = hdr_reg;

    `HBV_ASSERT_HOLDS(a_load_into_free_slot, !out_load || out_free,
        "result loaded while the output register still holds a word")
    `HBV_ASSERT_NEXT(a_clear_after_message, out_load,
        err_reg == ST_OK && sum_reg == '0 && !method_ok_reg,
        "message state not cleared after message end")
    `HBV_ASSERT_NEXT(a_first_error_sticks, err_reg != ST_OK && !out_load,
        err_reg == $past(err_reg), "latched error changed inside a message")
    `HBV_ASSERT_NEXT(a_stalled_result_holds, out_valid_reg && !results.ready,
        out_valid_reg && status_reg == $past(status_reg),
        "pending result dropped or changed under stall")

endmodule

// ----- rtl/http_header_block_validator_top.sv -----
// HTTP header block validator.
// items (sink): one word per byte of a message's method, header names and
// header values, tagged by part, with end-of-part and end-of-message markers.
// An end-of-message word carries the body length and yields one result word.
// results (source): status (first error of the message, 0 when clean) and the
// saturating header byte total; no other word produces a result.
// APB port: request_mode at 0x0, hdr_limit at 0x4, body_limit at 0x8;
// pready is tied high, reads return the register value. Write registers
// only while no message is in flight.
// Throughput: one word per cycle. Every word passes an input register and a
// single pass of check logic; an end-of-message result is loaded into the
// result register, where it is valid and can be taken at the next edge.
// Reset clears the message state and loads register defaults (request mode,
// 8192 header bytes, 1 MiB body). When results stalls, the pending result
// holds; byte words keep flowing, and the next end-of-message word waits in
// the input register, which then backpressures items.
module http_header_block_validator_top #(
    parameter int RESERVED_NAME_COUNT = hbv_pkg::RESERVED_NAME_COUNT_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    hbv_item_if.sink                       items,
    hbv_result_if.source                   results,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [hbv_pkg::PADDR_W-1:0]    paddr,
    input  logic [hbv_pkg::APB_DATA_W-1:0] pwdata,
    output logic [hbv_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import hbv_pkg::*;

    cfg_t   cfg;
    stage_t stage;
    logic   advance;

    // configuration registers
    hbv_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // input register; refills in the same cycle the core advances
    hbv_in_stage u_in (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items),
        .advance (advance),
        .stage   (stage)
    );

    // per-word checks, running state and result register
    hbv_core #(
        .RESERVED_NAME_COUNT (RESERVED_NAME_COUNT)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .stage   (stage),
        .advance (advance),
        .results (results)
    );

endmodule
